// File: src/lcd4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD 4-bit sequencer package
// Shared types, codes and timing constants for the character LCD sequencer.
// ----------------------------------------------------------------------------
package lcd4_pkg;

  // request action codes
  localparam logic [2:0] ACT_INIT  = 3'd0;
  localparam logic [2:0] ACT_CMD   = 3'd1;
  localparam logic [2:0] ACT_DATA  = 3'd2;
  localparam logic [2:0] ACT_GOTO  = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  // configuration register indexes
  localparam logic CFG_LINE_ONE = 1'b0;
  localparam logic CFG_LINE_TWO = 1'b1;

  localparam logic [6:0] LINE_ONE_RST = 7'd0;
  localparam logic [6:0] LINE_TWO_RST = 7'd64;

  // wait times in microseconds
  localparam logic [15:0] POWERUP_US   = 16'd50000;
  localparam logic [15:0] CMD_LONG_US  = 16'd2000;
  localparam logic [15:0] CMD_SHORT_US = 16'd50;
  localparam logic [15:0] CLEAR_XTR_US = 16'd2000;

  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME  = 8'h02;
  localparam logic       GOTO_FLAG = 1'b1;

  localparam int unsigned      INIT_RESULTS = 15;
  localparam logic [3:0]       INIT_LAST    = 4'(INIT_RESULTS - 1);
  localparam logic [3:0]       INIT_NIB_1ST = 4'd1;
  localparam logic [3:0]       INIT_CMD_1ST = 4'd5;
  localparam int unsigned      INIT_CMD_CLR = 2;

  // wake-up nibbles and their waits
  localparam logic [3:0]  INIT_NIB  [4] = '{4'h3, 4'h3, 4'h3, 4'h2};
  localparam logic [15:0] INIT_NIBW [4] = '{16'd5000, 16'd200, 16'd200, 16'd100};
  // function set, display on, clear, display on, entry mode
  localparam logic [7:0]  INIT_CMDS [5] = '{8'h28, 8'h0C, 8'h01, 8'h0C, 8'h06};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SEND
  } seq_state_e;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
    logic [1:0] row;
    logic [5:0] column;
  } req_t;

  typedef struct packed {
    logic        drive;
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] wait_us;
    logic        error;
    logic        last;
  } res_t;

  typedef struct packed {
    logic       capture;
    logic       load;
    logic [3:0] step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic req_known;
    logic res_last;
  } dp_sts_t;

endpackage

// File: src/lcd4_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD 4-bit sequencer controller
// Handshake state machine and result step counter.
// ----------------------------------------------------------------------------
module lcd4_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  lcd4_pkg::dp_sts_t   sts_i,
  output lcd4_pkg::ctrl_cmd_t cmd_o
);
  import lcd4_pkg::*;

  seq_state_e state_q, state_d;
  logic [3:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        step_d     = '0;
        // unknown actions are taken and dropped
        if (in_valid_i && sts_i.req_known) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        cmd_o.step = step_q;
        state_d    = ST_SEND;
      end
      ST_SEND: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (sts_i.res_last) begin
            state_d = ST_IDLE;
          end else begin
            // build the next result in the same cycle
            step_d     = step_q + 4'd1;
            cmd_o.load = 1'b1;
            cmd_o.step = step_q + 4'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: src/lcd4_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD 4-bit sequencer datapath
// Request and row base registers, result builder and output register.
// ----------------------------------------------------------------------------
module lcd4_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [6:0]          cfg_data_i,
  input  lcd4_pkg::req_t      in_data_i,
  input  lcd4_pkg::ctrl_cmd_t cmd_i,
  output lcd4_pkg::dp_sts_t   sts_o,
  output lcd4_pkg::res_t      out_data_o
);
  import lcd4_pkg::*;

  logic [6:0] line_one_q, line_two_q;
  req_t       req_q;
  res_t       res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_one_q <= LINE_ONE_RST;
      line_two_q <= LINE_TWO_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LINE_ONE: line_one_q <= cfg_data_i;
        CFG_LINE_TWO: line_two_q <= cfg_data_i;
        default:      line_one_q <= line_one_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= in_data_i;
    if (cmd_i.load)    res_q <= res_d;
  end

  // result for one step of the latched request
  always_comb begin
    logic [7:0]  byte_v;
    logic        rs_v;
    logic        half_v;
    logic [15:0] extra_v;
    logic [15:0] wait_v;
    logic [3:0]  nib_idx;
    logic [3:0]  cmd_off;
    logic [6:0]  addr_v;

    byte_v  = CMD_CLEAR;
    rs_v    = 1'b0;
    half_v  = cmd_i.step[0];
    extra_v = '0;
    nib_idx = cmd_i.step - INIT_NIB_1ST;
    cmd_off = cmd_i.step - INIT_CMD_1ST;
    addr_v  = ((req_q.row[0]) ? line_two_q : line_one_q) + {1'b0, req_q.column};
    res_d   = '0;

    case (req_q.action)
      ACT_INIT: begin
        byte_v  = INIT_CMDS[cmd_off[3:1]];
        half_v  = cmd_off[0];
        if (cmd_off[3:1] == 3'(INIT_CMD_CLR)) extra_v = CLEAR_XTR_US;
      end
      ACT_CMD:   byte_v = req_q.data_byte;
      ACT_DATA: begin
        byte_v = req_q.data_byte;
        rs_v   = 1'b1;
      end
      ACT_GOTO:  byte_v = {GOTO_FLAG, addr_v};
      ACT_CLEAR: extra_v = CLEAR_XTR_US;
      default:   byte_v = CMD_CLEAR;
    endcase

    if (rs_v) begin
      wait_v = CMD_SHORT_US;
    end else begin
      wait_v = ((byte_v == CMD_CLEAR) || (byte_v == CMD_HOME)) ? CMD_LONG_US
                                                               : CMD_SHORT_US;
      wait_v = wait_v + extra_v;
    end

    // generic byte transfer: high nibble then low nibble
    res_d.drive      = 1'b1;
    res_d.reg_select = rs_v;
    res_d.nibble     = half_v ? byte_v[3:0] : byte_v[7:4];
    res_d.wait_us    = half_v ? wait_v : '0;
    res_d.last       = half_v;

    if (req_q.action == ACT_INIT) begin
      res_d.last = (cmd_i.step == INIT_LAST);
      if (cmd_i.step == '0) begin
        res_d         = '0;
        res_d.wait_us = POWERUP_US;
      end else if (cmd_i.step < INIT_CMD_1ST) begin
        res_d.reg_select = 1'b0;
        res_d.nibble     = INIT_NIB[nib_idx[1:0]];
        res_d.wait_us    = INIT_NIBW[nib_idx[1:0]];
      end
    end else if ((req_q.action == ACT_GOTO) && req_q.row[1]) begin
      res_d       = '0;
      res_d.error = 1'b1;
      res_d.last  = 1'b1;
    end
  end

  assign sts_o.req_known = (in_data_i.action <= ACT_CLEAR);
  assign sts_o.res_last  = res_q.last;
  assign out_data_o      = res_q;

endmodule

// File: src/char_lcd_4bit_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD 4-bit sequencer
// Turns init, command, data, goto and clear requests into nibble transfers.
// The first result is valid once the controller has passed from idle through the load state.
// Throughput: one result per cycle while the output is not stalled, built by
//   the step counter in the controller; init gives 15 results, others 2 or 1.
// A new request is taken the cycle after the last result of the previous one.
// Reset (async, active low) returns to idle and restores the row bases 0/64.
// ----------------------------------------------------------------------------
module char_lcd_4bit_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_index_i,
  input  logic [6:0]     cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lcd4_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lcd4_pkg::res_t out_data_o
);
  import lcd4_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  lcd4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lcd4_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

  // an error result is always the only and final one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.error) |-> (out_data_o.last && !out_data_o.drive))
    else $error("error result not final");

  // no new request while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while result pending");

  // result is not yet valid in the cycle after a request is taken (load state)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result valid too early");

  // after the final result goes out, the block is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last) |=> (!out_valid_o && !in_stall_o))
    else $error("not idle after final result");

endmodule

// File: dv/char_lcd_4bit_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD 4-bit sequencer testbench
// Sends init, command, data, goto and clear requests with random gaps and
// output stalls, predicts every nibble transfer and checks them in order.
// ----------------------------------------------------------------------------
module char_lcd_4bit_sequencer_tb;
  import lcd4_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned IDLE_PCT      = 34;
  localparam logic [7:0]  LCD_HOME      = 8'h02;
  localparam logic [7:0]  LCD_FUNC_SET  = 8'h28;
  localparam logic [7:0]  LCD_DISP_ON   = 8'h0C;
  localparam logic [7:0]  LCD_ENTRY     = 8'h06;
  localparam logic [7:0]  LCD_SET_ADDR  = 8'h80;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_index_i;
  logic [6:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  req_t       in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  res_t       out_data_o;

  res_t        transfer_q[$];
  res_t        want_r;
  logic [6:0]  row0_base;
  logic [6:0]  row1_base;
  int unsigned mismatches;
  bit          steady;

  char_lcd_4bit_sequencer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  // ---------------------------------------------------------------- predictor
  function automatic void push_transfer(logic drv, logic rs, logic [3:0] nib,
                                        logic [15:0] hold_us, logic err,
                                        logic fin);
    res_t r;
    r.drive      = drv;
    r.reg_select = rs;
    r.nibble     = nib;
    r.wait_us    = hold_us;
    r.error      = err;
    r.last       = fin;
    transfer_q.push_back(r);
  endfunction

  // high nibble first with no hold, the low nibble carries the byte's hold
  function automatic void push_byte(logic [7:0] b, logic rs, logic [15:0] hold_us,
                                    logic fin);
    push_transfer(1'b1, rs, b[7:4], 16'd0, 1'b0, 1'b0);
    push_transfer(1'b1, rs, b[3:0], hold_us, 1'b0, fin);
  endfunction

  function automatic void push_command(logic [7:0] cmd, logic [15:0] extra_us,
                                       logic fin);
    logic [15:0] hold_us;
    hold_us = (cmd == CMD_CLEAR || cmd == LCD_HOME) ? 16'd2000 : 16'd50;
    push_byte(cmd, 1'b0, hold_us + extra_us, fin);
  endfunction

  function automatic void predict_transfers(req_t r);
    logic [6:0] base;
    logic [6:0] addr;
    case (r.action)
      ACT_INIT: begin
        push_transfer(1'b0, 1'b0, 4'h0, 16'd50000, 1'b0, 1'b0);
        push_transfer(1'b1, 1'b0, 4'h3, 16'd5000, 1'b0, 1'b0);
        push_transfer(1'b1, 1'b0, 4'h3, 16'd200, 1'b0, 1'b0);
        push_transfer(1'b1, 1'b0, 4'h3, 16'd200, 1'b0, 1'b0);
        push_transfer(1'b1, 1'b0, 4'h2, 16'd100, 1'b0, 1'b0);
        push_command(LCD_FUNC_SET, 16'd0, 1'b0);
        push_command(LCD_DISP_ON, 16'd0, 1'b0);
        push_command(CMD_CLEAR, 16'd2000, 1'b0);
        push_command(LCD_DISP_ON, 16'd0, 1'b0);
        push_command(LCD_ENTRY, 16'd0, 1'b1);
      end
      ACT_CMD:  push_command(r.data_byte, 16'd0, 1'b1);
      ACT_DATA: push_byte(r.data_byte, 1'b1, 16'd50, 1'b1);
      ACT_GOTO: begin
        if (r.row > 2'd1) begin
          push_transfer(1'b0, 1'b0, 4'h0, 16'd0, 1'b1, 1'b1);
        end else begin
          base = r.row[0] ? row1_base : row0_base;
          addr = 7'(base + r.column);
          push_command(LCD_SET_ADDR | {1'b0, addr}, 16'd0, 1'b1);
        end
      end
      ACT_CLEAR: push_command(CMD_CLEAR, 16'd2000, 1'b1);
      default: ;  // unknown actions are dropped
    endcase
  endfunction

  // ------------------------------------------------------------------ checker
  function automatic void check_field(string name, int unsigned exp_v,
                                      int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (transfer_q.size() == 0) begin
        $error("result with no request pending: %p", out_data_o);
        mismatches++;
      end else begin
        want_r = transfer_q.pop_front();
        check_field("drive", want_r.drive, out_data_o.drive);
        check_field("reg_select", want_r.reg_select, out_data_o.reg_select);
        check_field("nibble", want_r.nibble, out_data_o.nibble);
        check_field("wait_us", want_r.wait_us, out_data_o.wait_us);
        check_field("error", want_r.error, out_data_o.error);
        check_field("last", want_r.last, out_data_o.last);
      end
    end
  end

  // ------------------------------------------------------------------ drivers
  task automatic send_request(req_t r);
    int unsigned gap;
    @(negedge clk_i);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(4, 1);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (in_stall_o);
    predict_transfers(r);
  endtask

  task automatic make_request(logic [2:0] act, logic [7:0] b, logic [1:0] row,
                              logic [5:0] col);
    req_t r;
    r.action    = act;
    r.data_byte = b;
    r.row       = row;
    r.column    = col;
    send_request(r);
  endtask

  // wait out all pending transfers, plus slack for an ignored request
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (transfer_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [6:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_LINE_ONE) row0_base = val;
    else row1_base = val;
  endtask

  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    pick        = $urandom_range(99);
    r.data_byte = 8'($urandom_range(255));
    r.row       = 2'($urandom_range(3));
    r.column    = 6'($urandom_range(63));
    if (pick < 6) r.action = ACT_INIT;
    else if (pick < 30) r.action = ACT_CMD;
    else if (pick < 55) r.action = ACT_DATA;
    else if (pick < 85) r.action = ACT_GOTO;
    else if (pick < 93) r.action = ACT_CLEAR;
    else r.action = 3'($urandom_range(7, ACT_CLEAR + 1));
    // hit the long command waits more often
    if (r.action == ACT_CMD && $urandom_range(99) < 20)
      r.data_byte = $urandom_range(1) ? CMD_CLEAR : LCD_HOME;
    return r;
  endfunction

  // -------------------------------------------------------------------- tests
  task automatic test_reset_bases();
    make_request(ACT_INIT, 8'h00, 2'd0, 6'd0);
    make_request(ACT_GOTO, 8'h00, 2'd0, 6'd0);
    make_request(ACT_GOTO, 8'hFF, 2'd1, 6'd0);
    make_request(ACT_GOTO, 8'h00, 2'd1, 6'd63);
    settle();
  endtask

  task automatic test_bytes();
    make_request(ACT_CMD, 8'h00, 2'd0, 6'd0);
    make_request(ACT_CMD, 8'hFF, 2'd3, 6'd63);
    make_request(ACT_CMD, CMD_CLEAR, 2'd0, 6'd0);
    make_request(ACT_CMD, LCD_HOME, 2'd0, 6'd0);
    make_request(ACT_CMD, LCD_SET_ADDR, 2'd0, 6'd0);
    make_request(ACT_DATA, 8'h00, 2'd0, 6'd0);
    make_request(ACT_DATA, 8'hFF, 2'd0, 6'd0);
    make_request(ACT_DATA, 8'h5A, 2'd2, 6'd21);
    make_request(ACT_CLEAR, 8'hA5, 2'd1, 6'd42);
    settle();
  endtask

  task automatic test_goto_wrap();
    write_cfg(CFG_LINE_ONE, 7'd127);
    write_cfg(CFG_LINE_TWO, 7'd127);
    make_request(ACT_GOTO, 8'h00, 2'd0, 6'd63);
    make_request(ACT_GOTO, 8'h00, 2'd1, 6'd1);
    make_request(ACT_GOTO, 8'h00, 2'd2, 6'd0);
    make_request(ACT_GOTO, 8'hFF, 2'd3, 6'd63);
    settle();
    write_cfg(CFG_LINE_ONE, 7'd0);
    write_cfg(CFG_LINE_TWO, 7'd0);
    make_request(ACT_GOTO, 8'h00, 2'd0, 6'd0);
    make_request(ACT_GOTO, 8'h00, 2'd1, 6'd63);
    settle();
  endtask

  task automatic test_unknown_actions();
    make_request(3'd5, 8'hFF, 2'd3, 6'd63);
    make_request(ACT_DATA, 8'h41, 2'd0, 6'd0);
    make_request(3'd6, 8'h00, 2'd0, 6'd0);
    make_request(3'd7, 8'h81, 2'd1, 6'd33);
    make_request(ACT_DATA, 8'h42, 2'd0, 6'd0);
    settle();
  endtask

  task automatic test_random(int unsigned count, bit quiet);
    req_t        r;
    int unsigned known;
    known  = 0;
    steady = quiet;
    while (known < count) begin
      r = random_request();
      if (r.action <= ACT_CLEAR) known++;
      send_request(r);
    end
    settle();
    steady = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_LINE_ONE;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    row0_base   = 7'd0;
    row1_base   = 7'd64;
    mismatches  = 0;
    steady      = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_bases();
    test_bytes();
    test_goto_wrap();
    test_unknown_actions();

    write_cfg(CFG_LINE_ONE, 7'($urandom_range(127)));
    write_cfg(CFG_LINE_TWO, 7'($urandom_range(127)));
    test_random(80, 1'b0);
    write_cfg(CFG_LINE_ONE, 7'd127);
    write_cfg(CFG_LINE_TWO, 7'($urandom_range(127)));
    test_random(70, 1'b1);
    write_cfg(CFG_LINE_ONE, 7'($urandom_range(127)));
    write_cfg(CFG_LINE_TWO, 7'd0);
    test_random(70, 1'b0);
    write_cfg(CFG_LINE_ONE, 7'd0);
    write_cfg(CFG_LINE_TWO, 7'd64);
    test_random(65, 1'b0);

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
